[hw/rtl/bounded_deque_remove_by_value_macros.svh]
// Assertion helpers for the deque checker
`ifndef BOUNDED_DEQUE_REMOVE_BY_VALUE_MACROS_SVH
`define BOUNDED_DEQUE_REMOVE_BY_VALUE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define BDQ_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deque check failed");

// Concurrent assertion on the block clock and reset
`define BDQ_ASSERT(label, prop) \
  `BDQ_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

[hw/rtl/bdq_pkg.sv]
package bdq_pkg;

  localparam int KindW   = 3;
  localparam int StatusW = 2;
  localparam int ValueW  = 32;
  localparam int TotalW  = 5;

  // Operation codes carried by one input item
  typedef enum logic [KindW-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REMOVE     = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

endpackage

[hw/rtl/bdq_addr.sv]
// Circular slot address: (base + offset) mod DEPTH, one add and one
// compare-subtract. Shared by every memory access of the sequencer.
module bdq_addr #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [AW-1:0] base_i,
  input  logic [AW-1:0] off_i,
  output logic [AW-1:0] slot_o
);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  assign sum     = {1'b0, base_i} + {1'b0, off_i};
  assign wrapped = sum - (AW+1)'(DEPTH);

  // both operands stay below DEPTH, so one subtract wraps the sum
  assign slot_o = (sum >= (AW+1)'(DEPTH)) ? wrapped[AW-1:0] : sum[AW-1:0];

endmodule

[hw/rtl/bdq_mem.sv]
// Item store: one write port, one read port with registered read data
module bdq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bounded_deque_remove_by_value.sv]
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid_i/cfg_ready_o cfg_data_i (match mask)
// in        in         in_valid_i/in_stall_o   kind_i, item_value_i
// out       out        out_valid_o/out_stall_i status_o, popped_value_o, entry_total_o,
//                                              front_value_o, back_value_o
//
// One item at a time; in_stall_o is high from acceptance until the result is loaded
// into the output register. The pace of each item is set by the single read port and
// one address adder. Reset (rst_ni low, asynchronous) empties the queue and sets the
// mask to all ones; the store is not cleared. A stalled result holds while the next
// item is accepted.
module bounded_deque_remove_by_value
  import bdq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ValueW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [ValueW-1:0]   item_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StatusW-1:0]  status_o,
  output logic [ValueW-1:0]   popped_value_o,
  output logic [TotalW-1:0]   entry_total_o,
  output logic [ValueW-1:0]   front_value_o,
  output logic [ValueW-1:0]   back_value_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SB = (ITEM_BITS < ValueW) ? ITEM_BITS : ValueW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_FRONT,
    S_BACK_RD,
    S_BACK_CAP,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [KindW-1:0]     kind_q, kind_d;
  logic [SB-1:0]        val_q, val_d;
  logic [AW-1:0]        front_q, front_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  status_e              st_q, st_d;
  logic [SB-1:0]        popped_q, popped_d;
  logic [SB-1:0]        fval_q, fval_d;
  logic [SB-1:0]        bval_q, bval_d;
  logic [ValueW-1:0]    mask_q, mask_d;

  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   out_status_q, out_status_d;
  logic [ValueW-1:0]    out_popped_q, out_popped_d;
  logic [TotalW-1:0]    out_total_q, out_total_d;
  logic [ValueW-1:0]    out_front_q, out_front_d;
  logic [ValueW-1:0]    out_back_q, out_back_d;

  logic [AW-1:0]        off;
  logic [AW-1:0]        slot;
  logic                 mem_we;
  logic [SB-1:0]        mem_wdata;
  logic                 mem_re;
  logic [SB-1:0]        rdata;
  logic [CW-1:0]        idx_next;
  logic [CW-1:0]        count_dec;
  logic                 hit;

  bdq_addr #(.DEPTH(DEPTH)) u_addr (
    .base_i (front_q),
    .off_i  (off),
    .slot_o (slot)
  );

  bdq_mem #(.DEPTH(DEPTH), .WIDTH(SB)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (slot),
    .rdata_o (rdata)
  );

  assign idx_next  = idx_q + CW'(1);
  assign count_dec = count_q - CW'(1);
  // masked equality against the search value
  assign hit = ((rdata ^ val_q) & mask_q[SB-1:0]) == '0;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    val_d        = val_q;
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    st_d         = st_q;
    popped_d     = popped_q;
    fval_d       = fval_q;
    bval_d       = bval_q;
    mask_d       = mask_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_popped_d = out_popped_q;
    out_total_d  = out_total_q;
    out_front_d  = out_front_q;
    out_back_d   = out_back_q;
    off          = '0;
    mem_we       = 1'b0;
    mem_wdata    = val_q;
    mem_re       = 1'b0;

    if (cfg_valid_i) begin
      mask_d = cfg_data_i;
    end

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = kind_i;
          val_d    = item_value_i[SB-1:0];
          idx_d    = '0;
          st_d     = STATUS_OK;
          popped_d = '0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_FRONT;
        case (kind_q)
          KIND_PUSH_FRONT: begin
            if (count_q == CW'(DEPTH)) begin
              st_d = STATUS_FULL;
            end else begin
              off     = AW'(DEPTH - 1);
              mem_we  = 1'b1;
              front_d = slot;
              count_d = count_q + CW'(1);
            end
          end
          KIND_PUSH_BACK: begin
            if (count_q == CW'(DEPTH)) begin
              st_d = STATUS_FULL;
            end else begin
              off     = count_q[AW-1:0];
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
            end
          end
          KIND_POP_FRONT: begin
            if (count_q == '0) begin
              st_d = STATUS_EMPTY;
            end else begin
              off     = '0;
              mem_re  = 1'b1;
              state_d = S_POP;
            end
          end
          KIND_POP_BACK: begin
            if (count_q == '0) begin
              st_d = STATUS_EMPTY;
            end else begin
              off     = count_dec[AW-1:0];
              mem_re  = 1'b1;
              state_d = S_POP;
            end
          end
          KIND_REMOVE: begin
            if (count_q == '0) begin
              st_d = STATUS_NOT_FOUND;
            end else begin
              state_d = S_SRCH_RD;
            end
          end
          default: begin
            state_d = S_FRONT;
          end
        endcase
      end

      // capture popped item, advance pointers
      S_POP: begin
        popped_d = rdata;
        count_d  = count_dec;
        if (kind_q == KIND_POP_FRONT) begin
          off     = AW'(1);
          front_d = slot;
        end
        state_d = S_FRONT;
      end

      S_SRCH_RD: begin
        off     = idx_q[AW-1:0];
        mem_re  = 1'b1;
        state_d = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (hit) begin
          state_d = S_SH_RD;
        end else if (idx_next == count_q) begin
          st_d    = STATUS_NOT_FOUND;
          state_d = S_FRONT;
        end else begin
          idx_d   = idx_next;
          state_d = S_SRCH_RD;
        end
      end

      // close the gap: entry idx+1 moves to idx
      S_SH_RD: begin
        if (idx_next < count_q) begin
          off     = idx_next[AW-1:0];
          mem_re  = 1'b1;
          state_d = S_SH_WR;
        end else begin
          count_d = count_dec;
          state_d = S_FRONT;
        end
      end

      S_SH_WR: begin
        off       = idx_q[AW-1:0];
        mem_we    = 1'b1;
        mem_wdata = rdata;
        idx_d     = idx_next;
        state_d   = S_SH_RD;
      end

      // read back front and back items for the report
      S_FRONT: begin
        if (count_q == '0) begin
          fval_d  = '0;
          bval_d  = '0;
          state_d = S_DONE;
        end else begin
          off     = '0;
          mem_re  = 1'b1;
          state_d = S_BACK_RD;
        end
      end

      S_BACK_RD: begin
        fval_d  = rdata;
        off     = count_dec[AW-1:0];
        mem_re  = 1'b1;
        state_d = S_BACK_CAP;
      end

      S_BACK_CAP: begin
        bval_d  = rdata;
        state_d = S_DONE;
      end

      // load the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_popped_d = ValueW'(popped_q);
          out_total_d  = TotalW'(count_q);
          out_front_d  = ValueW'(fval_q);
          out_back_d   = ValueW'(bval_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= '0;
      val_q        <= '0;
      front_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      st_q         <= STATUS_OK;
      popped_q     <= '0;
      fval_q       <= '0;
      bval_q       <= '0;
      mask_q       <= '1;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_popped_q <= '0;
      out_total_q  <= '0;
      out_front_q  <= '0;
      out_back_q   <= '0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      val_q        <= val_d;
      front_q      <= front_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      st_q         <= st_d;
      popped_q     <= popped_d;
      fval_q       <= fval_d;
      bval_q       <= bval_d;
      mask_q       <= mask_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_popped_q <= out_popped_d;
      out_total_q  <= out_total_d;
      out_front_q  <= out_front_d;
      out_back_q   <= out_back_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign popped_value_o = out_popped_q;
  assign entry_total_o  = out_total_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;

endmodule

[hw/rtl/bdq_checker.sv]
`include "bounded_deque_remove_by_value_macros.svh"

// Port-level checks on the deque
module bdq_checker
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [StatusW-1:0]  status_o,
  input logic [ValueW-1:0]   popped_value_o,
  input logic [TotalW-1:0]   entry_total_o,
  input logic [ValueW-1:0]   front_value_o,
  input logic [ValueW-1:0]   back_value_o
);

  // a stalled result stays put
  `BDQ_ASSERT(a_out_hold, $past(out_valid_o && out_stall_i) |-> out_valid_o && $stable(status_o) && $stable(popped_value_o) && $stable(entry_total_o) && $stable(front_value_o) && $stable(back_value_o))

  // one item at a time: the block stalls right after taking an item
  `BDQ_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)

  // a pop on an empty queue leaves it empty and returns nothing
  `BDQ_ASSERT(a_empty_pop, out_valid_o && status_o == STATUS_EMPTY |-> entry_total_o == '0 && popped_value_o == '0)

  // an empty queue reports zero front and back items
  `BDQ_ASSERT(a_empty_ends, out_valid_o && entry_total_o == '0 && DEPTH < 32 |-> front_value_o == '0 && back_value_o == '0)

  // count never exceeds capacity
  `BDQ_ASSERT(a_total_bound, out_valid_o && DEPTH < 32 |-> entry_total_o <= TotalW'(DEPTH))

endmodule

bind bounded_deque_remove_by_value bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .popped_value_o (popped_value_o),
  .entry_total_o  (entry_total_o),
  .front_value_o  (front_value_o),
  .back_value_o   (back_value_o)
);
